// ===== rtl/trz_pkg.sv =====
// ----------------------------------------------------------------------------
// trz_pkg
// Shared constants for the triangle rasteriser with depth store.
// ----------------------------------------------------------------------------
package trz_pkg;

   localparam int MAX_WIDTH_DEF  = 128;
   localparam int MAX_HEIGHT_DEF = 64;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_DRAW  = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [7:0]  WIDTH_RST  = 8'd80;
   localparam logic [6:0]  HEIGHT_RST = 7'd40;
   localparam logic [15:0] DEPTH_FAR  = 16'hFFFF;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b00_0000_0001,
      S_IDLE  = 10'b00_0000_0010,
      S_START = 10'b00_0000_0100,
      S_SETUP = 10'b00_0000_1000,
      S_PIX   = 10'b00_0001_0000,
      S_MUL   = 10'b00_0010_0000,
      S_DIV   = 10'b00_0100_0000,
      S_WRITE = 10'b00_1000_0000,
      S_READ  = 10'b01_0000_0000,
      S_DONE  = 10'b10_0000_0000
   } state_type;

endpackage

// ===== rtl/triangle_rasterizer_zbuffer.sv =====
// ----------------------------------------------------------------------------
// triangle_rasterizer_zbuffer
// Edge-function triangle rasteriser over a depth and coverage store in one
// synchronous memory, with a read-modify-write per covered pixel.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid / req_ready  mode, vertices, read position
//  rsp       out        rsp_valid / rsp_ready  covered, depth, pixels_drawn
//  csr       in         psel / penable         image_width, image_height
//
//  clear: one store entry a cycle, over the whole MAX_WIDTH*MAX_HEIGHT store
//  draw: setup on one shared multiplier, then a walk over the box pixels; each
//  covered pixel adds 6 multiply steps, 16 divide steps and a depth-tested write
//  read: one registered store read; after reset the same clearing pass runs, no transaction taken
//  a result that is not taken holds the block in its done state
// ----------------------------------------------------------------------------
module triangle_rasterizer_zbuffer #(
   parameter int MAX_WIDTH  = trz_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = trz_pkg::MAX_HEIGHT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_v0_x,
   input  logic signed [15:0] req_v0_y,
   input  logic [15:0]        req_v0_z,
   input  logic signed [15:0] req_v1_x,
   input  logic signed [15:0] req_v1_y,
   input  logic [15:0]        req_v1_z,
   input  logic signed [15:0] req_v2_x,
   input  logic signed [15:0] req_v2_y,
   input  logic [15:0]        req_v2_z,
   input  logic [6:0]         req_read_x,
   input  logic [5:0]         req_read_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_covered,
   output logic [15:0]        rsp_depth,
   output logic [13:0]        rsp_pixels_drawn,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import trz_pkg::*;

   localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(STORE);
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);

   // configuration
   logic [7:0] width_ff;
   logic [6:0] height_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_HEIGHT) ? {25'd0, height_ff} : {24'd0, width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == REG_WIDTH) width_ff <= pwdata[7:0];
         else                       height_ff <= pwdata[6:0];
      end
   end

   // memory: {coverage, depth}
   logic [16:0]   store_mem [STORE];
   logic [16:0]   rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [16:0]   mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= store_mem[mem_raddr];
   end

   state_type state_ff, state_in;

   logic signed [15:0] x_ff [3];
   logic signed [15:0] y_ff [3];
   logic [15:0]        z_ff [3];
   logic signed [16:0] dx_ff [3];
   logic signed [16:0] dy_ff [3];
   logic signed [35:0] w_ff [3];
   logic signed [35:0] row_ff [3];
   logic signed [35:0] acc_ff, area_ff;
   logic [XW-1:0]      left_ff, right_ff, px_ff;
   logic [YW-1:0]      top_ff, bottom_ff, py_ff;
   logic [2:0]         k_ff;
   logic [51:0]        num_ff, rem_ff;
   logic [15:0]        q_ff;
   logic [3:0]         dcnt_ff;
   logic [13:0]        cnt_ff;
   logic [1:0]         mode_ff;
   logic [AW-1:0]      rd_addr_ff, clr_cnt_ff;
   logic               rd_ok_ff, clr_resp_ff;
   logic               rsp_valid_ff, rsp_cov_ff;
   logic [15:0]        rsp_depth_ff;
   logic [13:0]        rsp_cnt_ff;

   function automatic logic [16:0] lo_b(input logic signed [15:0] v, input logic [16:0] lim);
      logic [16:0] r;
      r = {5'd0, v[15:4]};
      if (v < 0) return 17'd0;
      return (r > lim) ? lim : r;
   endfunction

   function automatic logic [16:0] hi_b(input logic signed [15:0] v, input logic [16:0] lim);
      logic [16:0] s, r;
      s = {1'b0, v} + 17'd15;
      r = {4'd0, s[16:4]};
      if (v <= 0) return 17'd0;
      return (r > lim) ? lim : r;
   endfunction

   function automatic logic signed [15:0] min3(input logic signed [15:0] a, b, c);
      logic signed [15:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [15:0] max3(input logic signed [15:0] a, b, c);
      logic signed [15:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   // clamped image size
   logic [16:0] w_lim, h_lim;
   assign w_lim = (17'(width_ff) > 17'(MAX_WIDTH)) ? 17'(MAX_WIDTH) : 17'(width_ff);
   assign h_lim = (17'(height_ff) > 17'(MAX_HEIGHT)) ? 17'(MAX_HEIGHT) : 17'(height_ff);

   logic [16:0] left_c, right_c, top_c, bottom_c;
   assign left_c   = lo_b(min3(x_ff[0], x_ff[1], x_ff[2]), w_lim);
   assign right_c  = hi_b(max3(x_ff[0], x_ff[1], x_ff[2]), w_lim);
   assign top_c    = lo_b(min3(y_ff[0], y_ff[1], y_ff[2]), h_lim);
   assign bottom_c = hi_b(max3(y_ff[0], y_ff[1], y_ff[2]), h_lim);

   // pixel centre of the box corner, Q.4
   logic signed [17:0] cx0, cy0;
   assign cx0 = $signed(18'({left_ff, 4'b1000}));
   assign cy0 = $signed(18'({top_ff, 4'b1000}));

   // shared multiplier
   logic signed [18:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [35:0] prod;
   logic [1:0]         e_sel, a_sel;

   assign e_sel = k_ff[2:1] - 2'd1;
   assign a_sel = (k_ff[2:1] == 2'd3) ? 2'd0 : k_ff[2:1];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_MUL) begin
         mul_a = k_ff[0] ? $signed({1'b0, w_ff[k_ff[2:1]][35:18]})
                         : $signed({1'b0, w_ff[k_ff[2:1]][17:0]});
         mul_b = $signed({1'b0, z_ff[k_ff[2:1]]});
      end else if (k_ff[2:1] == 2'd0) begin
         // area from edge vectors 1 and 2
         mul_a = k_ff[0] ? 19'(dx_ff[1]) : 19'(dy_ff[1]);
         mul_b = k_ff[0] ? dy_ff[2] : dx_ff[2];
      end else begin
         // edge e starts at vertex e+1
         mul_a = k_ff[0] ? 19'(cy0 - 18'(y_ff[a_sel])) : 19'(cx0 - 18'(x_ff[a_sel]));
         mul_b = k_ff[0] ? dx_ff[e_sel] : dy_ff[e_sel];
      end
   end

   assign prod = mul_a * mul_b;

   logic signed [35:0] sub_res;
   assign sub_res = acc_ff - prod;

   logic [51:0] num_next;
   assign num_next = num_ff + (k_ff[0] ? (52'(prod[34:0]) << 18) : 52'(prod[34:0]));

   logic [51:0] cand;
   assign cand = 52'(area_ff[34:0]) << dcnt_ff;

   logic in_tri, last_col, last_row, nearer;
   assign in_tri   = !w_ff[0][35] && !w_ff[1][35] && !w_ff[2][35];
   assign last_col = (px_ff + XW'(1)) >= right_ff;
   assign last_row = (py_ff + YW'(1)) >= bottom_ff;
   assign nearer   = rdata_ff[15:0] > q_ff;

   logic [AW-1:0] pix_addr;
   assign pix_addr = AW'(py_ff * MAX_WIDTH + px_ff);

   logic          rd_ok_c;
   logic [AW-1:0] rd_addr_c;
   assign rd_ok_c   = (32'(req_read_x) < MAX_WIDTH) && (32'(req_read_y) < MAX_HEIGHT);
   assign rd_addr_c = rd_ok_c ? AW'(req_read_y * MAX_WIDTH + req_read_x) : '0;

   logic out_free;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pix_addr;
      mem_wdata = {1'b1, q_ff};
      mem_raddr = pix_addr;
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = {1'b0, DEPTH_FAR};
      end else if (state_ff == S_WRITE) begin
         mem_we = nearer;
      end
      // read address held so the memory output stays valid while the result waits
      if (state_ff == S_READ || (state_ff == S_DONE && mode_ff == MODE_READ))
         mem_raddr = rd_addr_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_cnt_ff == AW'(STORE - 1)) state_in = clr_resp_ff ? S_DONE : S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_CLEAR: state_in = S_CLEAR;
                  MODE_DRAW:  state_in = S_START;
                  MODE_READ:  state_in = S_READ;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_START: state_in = S_SETUP;
         S_SETUP: begin
            if (k_ff == 3'd1 && (sub_res <= 0 || left_ff >= right_ff || top_ff >= bottom_ff))
               state_in = S_DONE;
            else if (k_ff == 3'd7)
               state_in = S_PIX;
         end
         S_PIX: begin
            if (in_tri)                    state_in = S_MUL;
            else if (last_col && last_row) state_in = S_DONE;
         end
         S_MUL:   if (k_ff == 3'd5) state_in = S_DIV;
         S_DIV:   if (dcnt_ff == 4'd0) state_in = S_WRITE;
         S_WRITE: state_in = (last_col && last_row) ? S_DONE : S_PIX;
         S_READ:  state_in = S_DONE;
         S_DONE:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)                 rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: clr_cnt_ff <= clr_cnt_ff + AW'(1);
            S_IDLE: begin
               if (req_valid) begin
                  clr_cnt_ff  <= '0;
                  clr_resp_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            x_ff[0] <= req_v0_x; y_ff[0] <= req_v0_y; z_ff[0] <= req_v0_z;
            x_ff[1] <= req_v1_x; y_ff[1] <= req_v1_y; z_ff[1] <= req_v1_z;
            x_ff[2] <= req_v2_x; y_ff[2] <= req_v2_y; z_ff[2] <= req_v2_z;
            mode_ff      <= req_mode;
            rd_addr_ff   <= rd_addr_c;
            rd_ok_ff     <= rd_ok_c;
            cnt_ff       <= '0;
         end
         S_START: begin
            for (int e = 0; e < 3; e++) begin
               dx_ff[e] <= 17'(x_ff[(e + 2) % 3]) - 17'(x_ff[(e + 1) % 3]);
               dy_ff[e] <= 17'(y_ff[(e + 2) % 3]) - 17'(y_ff[(e + 1) % 3]);
            end
            // dx/dy of edge e run from vertex e+1 to vertex e+2
            left_ff   <= XW'(left_c);
            right_ff  <= XW'(right_c);
            top_ff    <= YW'(top_c);
            bottom_ff <= YW'(bottom_c);
            k_ff      <= '0;
         end
         S_SETUP: begin
            k_ff <= k_ff + 3'd1;
            if (!k_ff[0]) begin
               acc_ff <= prod;
            end else if (k_ff[2:1] == 2'd0) begin
               area_ff <= sub_res;
            end else begin
               w_ff[e_sel]   <= sub_res;
               row_ff[e_sel] <= sub_res;
            end
            px_ff <= left_ff;
            py_ff <= top_ff;
         end
         S_PIX: begin
            k_ff   <= '0;
            num_ff <= '0;
         end
         S_MUL: begin
            k_ff   <= k_ff + 3'd1;
            num_ff <= num_next;
            rem_ff <= num_next;
            dcnt_ff <= 4'd15;
            q_ff    <= '0;
         end
         S_DIV: begin
            dcnt_ff <= dcnt_ff - 4'd1;
            if (rem_ff >= cand) begin
               rem_ff <= rem_ff - cand;
               q_ff   <= {q_ff[14:0], 1'b1};
            end else begin
               q_ff   <= {q_ff[14:0], 1'b0};
            end
         end
         S_WRITE: if (nearer) cnt_ff <= cnt_ff + 14'd1;
         S_READ: ;
         S_DONE: begin
            if (out_free) begin
               rsp_cov_ff   <= (mode_ff == MODE_READ && rd_ok_ff) ? rdata_ff[16] : 1'b0;
               rsp_depth_ff <= (mode_ff != MODE_READ) ? 16'd0
                             : (rd_ok_ff ? rdata_ff[15:0] : DEPTH_FAR);
               rsp_cnt_ff   <= (mode_ff == MODE_DRAW) ? cnt_ff : 14'd0;
            end
         end
         default: ;
      endcase

      // walk the box: step along the row, or back to the left edge of the next row
      if ((state_ff == S_PIX && !in_tri) || state_ff == S_WRITE) begin
         if (!last_col) begin
            px_ff <= px_ff + XW'(1);
            for (int e = 0; e < 3; e++) w_ff[e] <= w_ff[e] + (36'(dy_ff[e]) <<< 4);
         end else begin
            px_ff <= left_ff;
            py_ff <= py_ff + YW'(1);
            for (int e = 0; e < 3; e++) begin
               row_ff[e] <= row_ff[e] - (36'(dx_ff[e]) <<< 4);
               w_ff[e]   <= row_ff[e] - (36'(dx_ff[e]) <<< 4);
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_covered      = rsp_cov_ff;
   assign rsp_depth        = rsp_depth_ff;
   assign rsp_pixels_drawn = rsp_cnt_ff;

`ifndef SYNTHESIS
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("store written while idle");

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("transaction taken during clearing pass");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside done state");

   a_write_in_box: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> (px_ff < right_ff && py_ff < bottom_ff))
      else $error("pixel write outside bounding box");
`endif

endmodule

// ===== tb/triangle_rasterizer_zbuffer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_rasterizer_zbuffer_test
// Drives clear, draw, read and unused-mode transactions into the rasteriser and keeps its
// own depth and coverage image, updated by every accepted clear and draw. Each
// response is checked field by field against the oldest pending prediction,
// across several image sizes and with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module triangle_rasterizer_zbuffer_test;
   import trz_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [2:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
   localparam logic [2:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};
   localparam int GRID_W = 128;
   localparam int GRID_H = 64;

   typedef struct {
      logic [1:0]         mode;
      logic signed [15:0] vx[3];
      logic signed [15:0] vy[3];
      logic [15:0]        vz[3];
      logic [6:0]         rx;
      logic [5:0]         ry;
   } prim_type;

   typedef struct {
      logic        covered;
      logic [15:0] depth;
      logic [13:0] drawn;
   } pixel_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = '0;
   logic signed [15:0] req_v0_x = '0, req_v0_y = '0, req_v1_x = '0;
   logic signed [15:0] req_v1_y = '0, req_v2_x = '0, req_v2_y = '0;
   logic [15:0]        req_v0_z = '0, req_v1_z = '0, req_v2_z = '0;
   logic [6:0]         req_read_x = '0;
   logic [5:0]         req_read_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_covered;
   logic [15:0]        rsp_depth;
   logic [13:0]        rsp_pixels_drawn;
   logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   triangle_rasterizer_zbuffer dut (.*);

   // scoreboard image and register copy
   logic [15:0] zimg[GRID_W*GRID_H];
   logic        cimg[GRID_W*GRID_H];
   int unsigned img_w = 80, img_h = 40;

   prim_type      pending_prims[$];
   prim_type      cur_prim;
   pixel_rsp_type expected_pixels[$];
   int            offered = 0, taken = 0;
   int            errors = 0;
   int            idle_pct = 0, stall_pct = 0;
   int            hold_left = 0;
   bit            hold_trigger = 1'b0;

   initial forever #5 clock = ~clock;

   initial begin
      #100_000_000;
      $display("[triangle_rasterizer_zbuffer] ERROR");
      $finish;
   end

   task automatic report(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
   endtask

   function automatic void queue_prim(prim_type p);
      pending_prims = {pending_prims, p};
   endfunction

   function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                       longint px, longint py);
      return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
   endfunction

   function automatic int unsigned rasterise(prim_type p);
      longint x[3], y[3], area, w0, w1, w2, num, zv, cx, cy, mn, mx;
      int unsigned w, h, left, right, top, bottom, cnt, idx;
      cnt = 0;
      for (int i = 0; i < 3; i++) begin
         x[i] = p.vx[i];
         y[i] = p.vy[i];
      end
      w = img_w > GRID_W ? GRID_W : img_w;
      h = img_h > GRID_H ? GRID_H : img_h;
      area = edge_val(x[0], y[0], x[1], y[1], x[2], y[2]);
      if (area <= 0) return 0;
      mn = x[0] < x[1] ? x[0] : x[1]; mn = mn < x[2] ? mn : x[2];
      mx = x[0] > x[1] ? x[0] : x[1]; mx = mx > x[2] ? mx : x[2];
      left  = mn < 0 ? 0 : ((mn >>> 4) > w ? w : int'(mn >>> 4));
      right = mx <= 0 ? 0 : (((mx + 15) >>> 4) > w ? w : int'((mx + 15) >>> 4));
      mn = y[0] < y[1] ? y[0] : y[1]; mn = mn < y[2] ? mn : y[2];
      mx = y[0] > y[1] ? y[0] : y[1]; mx = mx > y[2] ? mx : y[2];
      top    = mn < 0 ? 0 : ((mn >>> 4) > h ? h : int'(mn >>> 4));
      bottom = mx <= 0 ? 0 : (((mx + 15) >>> 4) > h ? h : int'((mx + 15) >>> 4));
      for (int unsigned py = top; py < bottom; py++) begin
         for (int unsigned px = left; px < right; px++) begin
            cx = px * 16 + 8;
            cy = py * 16 + 8;
            w0 = edge_val(x[1], y[1], x[2], y[2], cx, cy);
            w1 = edge_val(x[2], y[2], x[0], y[0], cx, cy);
            w2 = edge_val(x[0], y[0], x[1], y[1], cx, cy);
            if (w0 < 0 || w1 < 0 || w2 < 0) continue;
            num = w0 * longint'(p.vz[0]) + w1 * longint'(p.vz[1]) + w2 * longint'(p.vz[2]);
            zv = num / area;
            if (zv > 65535) zv = 65535;
            idx = py * GRID_W + px;
            if (longint'(zimg[idx]) > zv) begin
               zimg[idx] = zv[15:0];
               cimg[idx] = 1'b1;
               cnt++;
            end
         end
      end
      return cnt;
   endfunction

   function automatic pixel_rsp_type predict(prim_type p);
      pixel_rsp_type r;
      int unsigned idx;
      r = '{1'b0, 16'd0, 14'd0};
      case (p.mode)
         MODE_CLEAR: begin
            foreach (zimg[i]) begin
               zimg[i] = DEPTH_FAR;
               cimg[i] = 1'b0;
            end
         end
         MODE_DRAW: r.drawn = 14'(rasterise(p));
         MODE_READ: begin
            idx = p.ry * GRID_W + p.rx;
            r.covered = cimg[idx];
            r.depth = zimg[idx];
         end
         default: ;
      endcase
      return r;
   endfunction

   // response check first, then the new request prediction
   always @(posedge clock) begin
      pixel_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report("unexpected response", 0, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_covered !== want.covered) report("covered", rsp_covered, want.covered);
               if (rsp_depth !== want.depth) report("depth", rsp_depth, want.depth);
               if (rsp_pixels_drawn !== want.drawn)
                  report("pixels_drawn", rsp_pixels_drawn, want.drawn);
            end
         end
         if (req_valid && req_ready) begin
            expected_pixels = {expected_pixels, predict(cur_prim)};
            taken++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || offered == taken)) begin
         if (pending_prims.size() != 0 && $urandom_range(99) >= idle_pct) begin
            cur_prim = pending_prims.pop_front();
            req_mode   <= cur_prim.mode;
            req_v0_x   <= cur_prim.vx[0]; req_v0_y <= cur_prim.vy[0]; req_v0_z <= cur_prim.vz[0];
            req_v1_x   <= cur_prim.vx[1]; req_v1_y <= cur_prim.vy[1]; req_v1_z <= cur_prim.vz[1];
            req_v2_x   <= cur_prim.vx[2]; req_v2_y <= cur_prim.vy[2]; req_v2_z <= cur_prim.vz[2];
            req_read_x <= cur_prim.rx;
            req_read_y <= cur_prim.ry;
            req_valid  <= 1'b1;
            offered++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
      else if (hold_trigger) hold_left <= 2500;
   end

   always @(negedge clock) begin
      if (reset || hold_left != 0) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic csr_write(logic [2:0] addr, int unsigned value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= addr; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == ADDR_WIDTH) img_w = value & 8'hFF;
      else img_h = value & 7'h7F;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_prims.size() != 0 || offered != taken || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   function automatic prim_type tri_prim(int x0, int y0, int x1, int y1, int x2, int y2,
                                         int z0, int z1, int z2);
      prim_type p;
      p.mode = MODE_DRAW;
      p.vx = '{16'(x0), 16'(x1), 16'(x2)};
      p.vy = '{16'(y0), 16'(y1), 16'(y2)};
      p.vz = '{16'(z0), 16'(z1), 16'(z2)};
      p.rx = 7'($urandom); p.ry = 6'($urandom);
      return p;
   endfunction

   function automatic prim_type read_prim(int x, int y);
      prim_type p;
      p = tri_prim($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
      p.mode = MODE_READ;
      p.rx = 7'(x); p.ry = 6'(y);
      return p;
   endfunction

   function automatic prim_type misc_prim(logic [1:0] m);
      prim_type p;
      p = read_prim($urandom, $urandom);
      p.mode = m;
      return p;
   endfunction

   function automatic prim_type random_prim();
      prim_type p;
      int unsigned sel, w, h, bx, by, sz;
      w = img_w == 0 ? 1 : (img_w > GRID_W ? GRID_W : img_w);
      h = img_h == 0 ? 1 : (img_h > GRID_H ? GRID_H : img_h);
      sel = $urandom_range(999);
      if (sel < 5) return misc_prim(MODE_CLEAR);
      if (sel < 35) return misc_prim(MODE_UNUSED);
      if (sel < 380) return read_prim($urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1));
      if (sel < 388)
         return tri_prim($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
      // small triangle near the image, random winding
      sz = $urandom_range(2, 14) * 16;
      bx = $urandom_range(w + 2) * 16;
      by = $urandom_range(h + 2) * 16;
      p = tri_prim(int'(bx) - 32 + $urandom_range(sz), int'(by) - 32 + $urandom_range(sz),
                   int'(bx) - 32 + $urandom_range(sz), int'(by) - 32 + $urandom_range(sz),
                   int'(bx) - 32 + $urandom_range(sz), int'(by) - 32 + $urandom_range(sz),
                   $urandom, $urandom, $urandom);
      if ($urandom_range(3) == 0) p.vz = '{p.vz[0], p.vz[0], p.vz[0]};
      return p;
   endfunction

   initial begin
      int ws[4] = '{128, 255, 37, 0};
      int hs[4] = '{64, 127, 23, 0};
      int ip[4] = '{0, 79, 0, 17};
      int sp[4] = '{0, 0, 79, 17};
      // the store comes out of reset cleared
      foreach (zimg[i]) begin
         zimg[i] = DEPTH_FAR;
         cimg[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      csr_write(ADDR_WIDTH, 80);
      csr_write(ADDR_HEIGHT, 40);
      queue_prim(misc_prim(MODE_CLEAR));
      queue_prim(read_prim(0, 0));
      queue_prim(tri_prim(16, 16, 16, 160, 160, 16, 40000, 40000, 40000));
      queue_prim(tri_prim(16, 16, 16, 160, 160, 16, 40000, 40000, 40000));
      queue_prim(tri_prim(16, 16, 16, 160, 160, 16, 100, 65535, 0));
      queue_prim(tri_prim(16, 16, 160, 16, 16, 160, 0, 0, 0));
      queue_prim(tri_prim(16, 16, 80, 80, 160, 160, 0, 0, 0));
      queue_prim(tri_prim(0, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_prim(read_prim(2, 2));
      queue_prim(read_prim(3, 1));
      queue_prim(tri_prim(-32768, -32768, -32768, 32767, 32767, -32768,
                          65535, 65535, 65535));
      queue_prim(tri_prim(-32768, -32768, -32768, 32767, 32767, -32768,
                          65534, 1, 30000));
      queue_prim(read_prim(79, 39));
      queue_prim(read_prim(127, 63));
      queue_prim(read_prim(100, 50));
      queue_prim(misc_prim(MODE_UNUSED));
      queue_prim(tri_prim(-40, -40, -40, 900, 1500, -40, 7, 9, 11));
      queue_prim(read_prim(0, 0));
      queue_prim(misc_prim(MODE_CLEAR));
      queue_prim(read_prim(5, 5));
      wait_idle();

      for (int ph = 0; ph < 4; ph++) begin
         csr_write(ADDR_WIDTH, ws[ph]);
         csr_write(ADDR_HEIGHT, hs[ph]);
         idle_pct = ip[ph];
         stall_pct = sp[ph];
         if (ph == 1) begin
            hold_trigger = 1'b1;
            @(posedge clock);
            @(negedge clock);
            hold_trigger = 1'b0;
         end
         for (int i = 0; i < 135; i++) queue_prim(random_prim());
         // sizes follow the last write: keep the extremes for a few items only
         if (ph == 3) begin
            wait_idle();
            csr_write(ADDR_WIDTH, 1);
            csr_write(ADDR_HEIGHT, 1);
            for (int i = 0; i < 20; i++) queue_prim(random_prim());
         end
         wait_idle();
      end

      repeat (200) @(posedge clock);
      if (errors == 0) $display("[triangle_rasterizer_zbuffer] OK");
      else $display("[triangle_rasterizer_zbuffer] ERROR");
      $finish;
   end

endmodule
